FILE: design/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg: shared types and constants of the haptic pattern duty generator
// Beat layouts, configuration bundle, job record and arithmetic constants.
// ----------------------------------------------------------------------------
package hpd_pkg;

	localparam int MAX_MOTORS = 8;
	localparam int IDX_W      = $clog2(MAX_MOTORS);
	localparam int CNT_W      = $clog2(MAX_MOTORS + 1);

	localparam int TIME_W     = 32;
	localparam int STEP_BITS  = 4;
	localparam int DIV_STEPS  = TIME_W / STEP_BITS;
	localparam int DSTEP_W    = $clog2(DIV_STEPS);

	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);

	// floor(x / 100) = (x * RECIP100) >> SHIFT100, exact for x < 2^30 / 76
	localparam logic [23:0] RECIP100 = 24'd10737419;
	localparam int          SHIFT100 = 30;
	// floor(x / 3) = (x * RECIP3) >> SHIFT3, exact for x < 2^17
	localparam logic [15:0] RECIP3   = 16'd43691;
	localparam int          SHIFT3   = 17;

	localparam logic [6:0] PCT_FULL = 7'd100;

	// configuration register indexes
	localparam logic [2:0] REG_MAX_DUTY   = 3'd0;
	localparam logic [2:0] REG_MOTORS     = 3'd1;
	localparam logic [2:0] REG_PULSE_PER  = 3'd2;
	localparam logic [2:0] REG_PULSE_ON   = 3'd3;
	localparam logic [2:0] REG_WAVE_STEP  = 3'd4;
	localparam logic [2:0] REG_BEAT_PER   = 3'd5;
	localparam logic [2:0] REG_BEAT_ON    = 3'd6;
	localparam logic [2:0] REG_BEAT_GAP   = 3'd7;

	typedef enum logic [1:0] {
		OP_CONST = 2'd0,
		OP_PULSE = 2'd1,
		OP_WAVE  = 2'd2,
		OP_BEAT  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] intensity;
		logic [31:0]        time_ms;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  motor_index;
		logic [15:0] duty;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] max_duty;
		logic [3:0]  motor_count;
		logic [15:0] pulse_period;
		logic [15:0] pulse_on_time;
		logic [15:0] wave_step_time;
		logic [15:0] beat_period;
		logic [15:0] beat_on_time;
		logic [15:0] beat_gap_time;
	} cfg_t;

	// classified item handed from the front to the back
	typedef struct packed {
		op_t              op;
		logic [15:0]      duty;
		logic [15:0]      duty3;
		logic [31:0]      pos;
		logic [IDX_W-1:0] prim;
	} job_t;

	function automatic logic [CNT_W-1:0] eff_motors(input cfg_t c);
		logic [CNT_W-1:0] lim;
		lim = CNT_W'(MAX_MOTORS);
		if (CNT_W'(c.motor_count) > lim) begin
			return lim;
		end
		return CNT_W'(c.motor_count);
	endfunction

endpackage

FILE: design/hpd_front.sv
// ----------------------------------------------------------------------------
// hpd_front: command intake and classification
// Scales the intensity, divides the timestamp by the pattern period four
// bits a cycle (last step held while the queue is full), queues the job.
// ----------------------------------------------------------------------------
module hpd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  hpd_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  hpd_pkg::cmd_t cmd,
	output logic          push,
	output hpd_pkg::job_t job,
	input  logic          q_full
);
	import hpd_pkg::*;

	typedef enum logic {F_IDLE, F_DIV} fstate_t;

	fstate_t            state_q;
	logic [DSTEP_W-1:0] cnt_q;

	op_t              op_q;
	logic [6:0]       pct_q;
	logic [31:0]      time_q;
	logic [31:0]      dvd_q;
	logic [15:0]      div_q;
	logic             divz_q;
	logic [15:0]      rem_q;
	logic [IDX_W-1:0] mod_q;
	logic [22:0]      prod_q;
	logic [46:0]      scaled_q;
	logic [31:0]      d3_q;

	logic [CNT_W-1:0] n;
	logic [6:0]       pct_in;
	logic             accept;
	logic             last_step;
	logic             done_ok;
	logic             step_en;
	logic [15:0]      rem_nx;
	logic [31:0]      dvd_nx;
	logic [IDX_W-1:0] mod_nx;
	logic [15:0]      duty_w;
	logic [15:0]      div_sel;

	assign n         = eff_motors(cfg);
	assign last_step = (state_q == F_DIV) && (cnt_q == DSTEP_W'(DIV_STEPS - 1));
	assign done_ok   = !q_full || (n == '0);
	assign step_en   = !(last_step && !done_ok);
	assign cmd_stall = (state_q == F_DIV) && !(last_step && done_ok);
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = last_step && done_ok && (n != '0);

	// percent clamp: negative -> 0, above full scale -> 100
	always_comb begin
		priority if (cmd.intensity[15]) begin
			pct_in = '0;
		end else if (cmd.intensity > 16'sd100) begin
			pct_in = PCT_FULL;
		end else begin
			pct_in = cmd.intensity[6:0];
		end
	end

	always_comb begin
		unique case (cmd.op)
			OP_WAVE: div_sel = cfg.wave_step_time;
			OP_BEAT: div_sel = cfg.beat_period;
			default: div_sel = cfg.pulse_period;
		endcase
	end

	// restoring division, quotient folded mod n on the fly
	always_comb begin : div_step
		logic [15:0]      r;
		logic [31:0]      d;
		logic [IDX_W-1:0] m;
		logic [16:0]      r2;
		logic [IDX_W:0]   m2;
		logic             ge;
		r = rem_q;
		d = dvd_q;
		m = mod_q;
		for (int j = 0; j < STEP_BITS; j++) begin
			r2 = {r, d[31]};
			d  = {d[30:0], 1'b0};
			ge = (r2 >= {1'b0, div_q});
			r  = ge ? 16'(r2 - {1'b0, div_q}) : r2[15:0];
			m2 = {m, ge};
			m  = (CNT_W'(m2) >= n) ? IDX_W'(CNT_W'(m2) - n) : m2[IDX_W-1:0];
		end
		rem_nx = r;
		dvd_nx = d;
		mod_nx = m;
	end

	assign duty_w = scaled_q[SHIFT100 +: 16];

	always_comb begin
		job.op    = op_q;
		job.duty  = duty_w;
		job.duty3 = 16'(d3_q >> SHIFT3);
		job.pos   = divz_q ? time_q : 32'(rem_nx);
		job.prim  = divz_q ? '0 : mod_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			if (accept) begin
				state_q <= F_DIV;
				cnt_q   <= '0;
			end else if ((state_q == F_DIV) && step_en) begin
				if (last_step) begin
					state_q <= F_IDLE;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.op;
			pct_q  <= pct_in;
			time_q <= cmd.time_ms;
			dvd_q  <= cmd.time_ms;
			div_q  <= div_sel;
			divz_q <= (div_sel == '0);
			rem_q  <= '0;
			mod_q  <= '0;
		end else if ((state_q == F_DIV) && step_en) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
			mod_q <= mod_nx;
		end
		// scaling chain: prod_q, then scaled_q, then d3_q
		prod_q   <= pct_q * cfg.max_duty;
		scaled_q <= prod_q * RECIP100;
		d3_q     <= duty_w * RECIP3;
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV && cnt_q != DSTEP_W'(DIV_STEPS - 1)) |-> cmd_stall)
		else $error("front took a command mid-division");

endmodule

FILE: design/hpd_queue.sv
// ----------------------------------------------------------------------------
// hpd_queue: job queue between front and back
// Small flop FIFO so the divider and the beat sequencer stall independently.
// ----------------------------------------------------------------------------
module hpd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hpd_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output hpd_pkg::job_t rd_job,
	output logic          empty
);
	import hpd_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full   = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop) && !(pop && empty))
		else $error("queue overrun or underrun");

endmodule

FILE: design/hpd_back.sv
// ----------------------------------------------------------------------------
// hpd_back: per-motor beat sequencer
// Walks motors 0..n-1 of the current job, one beat a cycle while the output
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module hpd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  hpd_pkg::cfg_t cfg,
	input  hpd_pkg::job_t q_job,
	input  logic          q_empty,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_stall,
	output hpd_pkg::res_t res
);
	import hpd_pkg::*;

	job_t             cur_q;
	logic             cur_vld_q;
	logic [IDX_W-1:0] idx_q;
	res_t             res_q;
	logic             res_vld_q;

	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] idx_w;
	logic [CNT_W-1:0] sec;
	logic [CNT_W-1:0] b;
	logic             out_free;
	logic             beat_go;
	logic             is_last;
	logic             center;
	logic             outer;
	logic [16:0]      th_on;
	logic [16:0]      th_gap;
	logic [17:0]      th_two;
	logic [15:0]      duty_calc;

	assign n        = eff_motors(cfg);
	assign idx_w    = CNT_W'(idx_q);
	assign out_free = !res_vld_q || !res_stall;
	assign beat_go  = cur_vld_q && out_free;
	assign is_last  = (idx_w == n - 1'b1);
	assign pop      = !q_empty && (!cur_vld_q || (beat_go && is_last));

	// wave neighbor and heartbeat centre pair A = n/2-1, B = n/2
	assign sec    = (CNT_W'(cur_q.prim) + 1'b1 == n) ? '0 : CNT_W'(cur_q.prim) + 1'b1;
	assign b      = n >> 1;
	assign center = ((b != '0) && (idx_w == b - 1'b1)) || (idx_w == b);
	assign outer  = ((b >= CNT_W'(2)) && (idx_w == b - CNT_W'(2))) || (idx_w == b + 1'b1);
	assign th_on  = 17'(cfg.beat_on_time);
	assign th_gap = th_on + 17'(cfg.beat_gap_time);
	assign th_two = 18'(th_gap) + 18'(cfg.beat_on_time);

	always_comb begin
		duty_calc = '0;
		unique case (cur_q.op)
			OP_CONST: duty_calc = cur_q.duty;
			OP_PULSE: begin
				if (cur_q.pos < 32'(cfg.pulse_on_time)) begin
					duty_calc = cur_q.duty;
				end
			end
			OP_WAVE: begin
				priority if (idx_q == cur_q.prim) begin
					duty_calc = cur_q.duty;
				end else if (idx_w == sec) begin
					duty_calc = cur_q.duty >> 1;
				end else begin
					duty_calc = '0;
				end
			end
			OP_BEAT: begin
				priority if (cur_q.pos < 32'(th_on)) begin
					if (center) begin
						duty_calc = cur_q.duty;
					end else if (outer) begin
						duty_calc = cur_q.duty3;
					end
				end else if (cur_q.pos < 32'(th_gap)) begin
					duty_calc = '0;
				end else if (cur_q.pos < 32'(th_two)) begin
					if (center) begin
						duty_calc = cur_q.duty;
					end
				end else begin
					duty_calc = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (beat_go) begin
				if (is_last) begin
					cur_vld_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
			if (beat_go) begin
				res_vld_q <= 1'b1;
			end else if (out_free) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_job;
		end
		if (beat_go) begin
			res_q.motor_index <= idx_q;
			res_q.duty        <= duty_calc;
			res_q.last        <= is_last;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	a_last_is_top: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.last) |-> (CNT_W'(res_q.motor_index) == n - 1'b1))
		else $error("last flag on wrong motor");

	a_index_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !res_stall && !res_q.last) |=>
		(res_vld_q && res_q.motor_index == $past(res_q.motor_index) + 1'b1))
		else $error("motor beats not contiguous");

	a_duty_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> (res_q.duty <= cfg.max_duty))
		else $error("duty above max_duty");

endmodule

FILE: design/haptic_pattern_duty_generator_top.sv
// ----------------------------------------------------------------------------
// haptic_pattern_duty_generator_top: pattern to per-motor PWM duty
// Configuration registers, classifying front end, job queue, beat sequencer.
// ----------------------------------------------------------------------------
// Usage
//   cmd channel: one beat carries op, intensity and time_ms; taken at a clock
//   edge with cmd_valid high and cmd_stall low.
//   res channel: one beat per motor in use, motor 0 first, last set on motor
//   n-1 (n = motor_count, capped at 8); taken with res_valid high and
//   res_stall low. motor_count of zero yields no beats.
//   cfg port: cfg_we writes cfg_data into register cfg_idx at the clock edge;
//   write only while no command is in flight.
// Timing
//   The front divides time_ms by the selected period four quotient bits per
//   cycle, the last step waiting while the queue is full; the next command
//   is taken during the last divide step. The back pops each job from the
//   queue and registers its result beats, one beat per cycle while
//   res_stall is low. Sustained rate is bounded by the divider in the front
//   and by one beat a cycle in the back.
// Reset: arst_n low clears all handshake state and loads register defaults.
// Back pressure: a stalled result beat holds in the output register; the
//   two-entry job queue fills, then cmd_stall rises.
// ----------------------------------------------------------------------------
module haptic_pattern_duty_generator_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  hpd_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output hpd_pkg::res_t res,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [15:0]   cfg_data
);
	import hpd_pkg::*;

	cfg_t cfg_q;
	job_t f_job;
	job_t q_job;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// register file, defaults per spec
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_duty       <= 16'd255;
			cfg_q.motor_count    <= 4'd8;
			cfg_q.pulse_period   <= 16'd1000;
			cfg_q.pulse_on_time  <= 16'd500;
			cfg_q.wave_step_time <= 16'd200;
			cfg_q.beat_period    <= 16'd1200;
			cfg_q.beat_on_time   <= 16'd100;
			cfg_q.beat_gap_time  <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_DUTY:  cfg_q.max_duty       <= cfg_data;
				REG_MOTORS:    cfg_q.motor_count    <= cfg_data[3:0];
				REG_PULSE_PER: cfg_q.pulse_period   <= cfg_data;
				REG_PULSE_ON:  cfg_q.pulse_on_time  <= cfg_data;
				REG_WAVE_STEP: cfg_q.wave_step_time <= cfg_data;
				REG_BEAT_PER:  cfg_q.beat_period    <= cfg_data;
				REG_BEAT_ON:   cfg_q.beat_on_time   <= cfg_data;
				REG_BEAT_GAP:  cfg_q.beat_gap_time  <= cfg_data;
			endcase
		end
	end

	// front: intensity scaling and period division
	hpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.push      (push),
		.job       (f_job),
		.q_full    (q_full)
	);

	// decouples the divider from the beat sequencer
	hpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (f_job),
		.full   (q_full),
		.pop    (pop),
		.rd_job (q_job),
		.empty  (q_empty)
	);

	// back: one duty beat per motor
	hpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_job     (q_job),
		.q_empty   (q_empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

FILE: bench/haptic_pattern_duty_generator_top_tb.sv
// ----------------------------------------------------------------------------
// haptic_pattern_duty_generator_top_tb: self-checking bench for the duty generator
// Drives pattern commands with bursty valid and a stalling result side, models
// the per-motor duty of every accepted command and compares each result beat.
// Register settings change between phases, from reset defaults to the extremes.
// ----------------------------------------------------------------------------
module haptic_pattern_duty_generator_top_tb;

	import hpd_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int CYCLE_LIMIT   = 400000;
	// quiet time before a register write; covers a command still in the
	// divider that yields no beats (motor count zero)
	localparam int IDLE_CYCLES   = 48;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 27;
	localparam int REPORT_LIMIT  = 10;

	// ------------------------------------------------------------------
	// Duty predictor and store of pending duty beats
	// ------------------------------------------------------------------
	class duty_scoreboard;
		cfg_t regs;
		res_t duty_q[$];
		int   cmds;
		int   beats;
		int   errors;

		function new();
			// register defaults after reset
			regs.max_duty       = 16'd255;
			regs.motor_count    = 4'd8;
			regs.pulse_period   = 16'd1000;
			regs.pulse_on_time  = 16'd500;
			regs.wave_step_time = 16'd200;
			regs.beat_period    = 16'd1200;
			regs.beat_on_time   = 16'd100;
			regs.beat_gap_time  = 16'd100;
			cmds   = 0;
			beats  = 0;
			errors = 0;
		endfunction

		function longint unsigned cycle_pos(longint unsigned t, longint unsigned per);
			return (per == 0) ? t : t % per;
		endfunction

		// accepted command: work out one duty beat per motor in use
		function void note_cmd(cmd_t c);
			int unsigned     n;
			int unsigned     pct;
			int unsigned     full;
			int unsigned     prim;
			int unsigned     sec;
			int unsigned     b;
			int unsigned     a;
			bit              has_a;
			longint unsigned pos;
			longint unsigned t;
			int unsigned     lvl[MAX_MOTORS];
			shortint         ival;
			res_t            r;
			cmds++;
			n = (regs.motor_count > MAX_MOTORS) ? MAX_MOTORS : regs.motor_count;
			if (n == 0) begin
				return;
			end
			ival = c.intensity;
			if (ival < 0) begin
				pct = 0;
			end else if (ival > 100) begin
				pct = 100;
			end else begin
				pct = ival;
			end
			full = pct * regs.max_duty / 100;
			t    = c.time_ms;
			foreach (lvl[i]) lvl[i] = 0;
			case (c.op)
				OP_CONST: begin
					for (int i = 0; i < n; i++) lvl[i] = full;
				end
				OP_PULSE: begin
					if (cycle_pos(t, regs.pulse_period) < regs.pulse_on_time) begin
						for (int i = 0; i < n; i++) lvl[i] = full;
					end
				end
				OP_WAVE: begin
					prim = (regs.wave_step_time == 0) ? 0 :
						int'((t / regs.wave_step_time) % n);
					sec  = (prim + 1) % n;
					lvl[sec]  = full / 2;
					lvl[prim] = full;
				end
				default: begin
					pos   = cycle_pos(t, regs.beat_period);
					b     = n / 2;
					has_a = (b >= 1);
					a     = has_a ? b - 1 : 0;
					if (pos < regs.beat_on_time) begin
						if (has_a) lvl[a] = full;
						if (b < n) lvl[b] = full;
						if (has_a && a >= 1) lvl[a-1] = full / 3;
						if (b + 1 < n) lvl[b+1] = full / 3;
					end else if (pos < longint'(regs.beat_on_time) + regs.beat_gap_time) begin
						// pause between the two beats
					end else if (pos < 2 * longint'(regs.beat_on_time) + regs.beat_gap_time) begin
						if (has_a) lvl[a] = full;
						if (b < n) lvl[b] = full;
					end
				end
			endcase
			for (int i = 0; i < n; i++) begin
				r.motor_index = 3'(i);
				r.duty        = (lvl[i] > regs.max_duty) ? regs.max_duty : 16'(lvl[i]);
				r.last        = (i + 1 == n);
				duty_q.push_back(r);
			end
		endfunction

		function void check_res(res_t got);
			res_t want;
			beats++;
			if (duty_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("unexpected duty beat: idx %0d duty %0d last %0b",
						got.motor_index, got.duty, got.last);
				end
				return;
			end
			want = duty_q.pop_front();
			if (got.motor_index !== want.motor_index || got.duty !== want.duty ||
					got.last !== want.last) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("duty beat %0d: want idx %0d duty %0d last %0b, got idx %0d duty %0d last %0b",
						beats, want.motor_index, want.duty, want.last,
						got.motor_index, got.duty, got.last);
				end
			end
		endfunction

		function int pending();
			return duty_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_data;

	haptic_pattern_duty_generator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	duty_scoreboard sb = new();

	int cycle_cnt   = 0;
	int burst_left  = 0;
	int settings    = 1;   // reset defaults count as the first setting
	bit hold_req    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Watchdog: the only other way out of the run
	// ------------------------------------------------------------------
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("haptic_pattern_duty_generator_top_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: check every taken beat, then pick next cycle's stall.
	// Stall follows its own modes (none, light, heavy, alternating), and a
	// hold request from the command side turns into a long stretch of
	// stall counted here, so the job queue fills and cmd_stall rises.
	// ------------------------------------------------------------------
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		bit stall_nxt;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				sb.check_res(res);
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_nxt = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: stall_nxt = 1'b0;
					1: stall_nxt = ($urandom_range(0, 3) == 0);
					2: stall_nxt = ($urandom_range(0, 3) != 0);
					default: stall_nxt = mode_left[0];
				endcase
			end
			res_stall <= stall_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Command side helpers
	// ------------------------------------------------------------------

	// offer one beat and hold it until taken; valid stays up on return so
	// a back-to-back beat needs no lowering
	task automatic send_cmd(input cmd_t c);
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_cmd(c);
	endtask

	// burst bookkeeping after a taken beat: at burst end drop valid for a gap
	task automatic after_beat(input bit final_one);
		int gap;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0 && !final_one) begin
			gap = $urandom_range(1, 12);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
	endtask

	// wait for every pending beat, then let the front end settle
	task automatic wait_idle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// all eight registers, block idle; motor count carries junk in the
	// upper data bits, which the register must drop
	task automatic load_cfg(input cfg_t c);
		logic [11:0] junk;
		junk = 12'($urandom);
		write_reg(REG_MAX_DUTY,  c.max_duty);
		write_reg(REG_MOTORS,    {junk, c.motor_count});
		write_reg(REG_PULSE_PER, c.pulse_period);
		write_reg(REG_PULSE_ON,  c.pulse_on_time);
		write_reg(REG_WAVE_STEP, c.wave_step_time);
		write_reg(REG_BEAT_PER,  c.beat_period);
		write_reg(REG_BEAT_ON,   c.beat_on_time);
		write_reg(REG_BEAT_GAP,  c.beat_gap_time);
		cfg_we <= 1'b0;
		sb.regs = c;
		settings++;
	endtask

	function automatic cmd_t mk_cmd(input op_t op, input int inten, input int unsigned t);
		cmd_t c;
		c.op        = op;
		c.intensity = 16'(inten);
		c.time_ms   = t;
		return c;
	endfunction

	// settings per phase: low extremes, high extremes, no motors,
	// zero periods, a set of small periods, then random small periods so
	// the time lands in every part of the pulse and heartbeat cycles
	function automatic cfg_t phase_cfg(input int k);
		cfg_t c;
		case (k)
			0: begin
				c = '{max_duty: 16'hFFFF, motor_count: 4'd1, pulse_period: 16'd1,
					pulse_on_time: 16'd0, wave_step_time: 16'd1, beat_period: 16'd1,
					beat_on_time: 16'd0, beat_gap_time: 16'd0};
			end
			1: begin
				c = '{max_duty: 16'd0, motor_count: 4'd15, pulse_period: 16'hFFFF,
					pulse_on_time: 16'hFFFF, wave_step_time: 16'hFFFF,
					beat_period: 16'hFFFF, beat_on_time: 16'hFFFF, beat_gap_time: 16'hFFFF};
			end
			2: begin
				c = '{max_duty: 16'd255, motor_count: 4'd0, pulse_period: 16'd100,
					pulse_on_time: 16'd50, wave_step_time: 16'd10, beat_period: 16'd300,
					beat_on_time: 16'd40, beat_gap_time: 16'd40};
			end
			3: begin
				c = '{max_duty: 16'd1000, motor_count: 4'd2, pulse_period: 16'd0,
					pulse_on_time: 16'd4000, wave_step_time: 16'd0, beat_period: 16'd0,
					beat_on_time: 16'd1500, beat_gap_time: 16'd1500};
			end
			4: begin
				c = '{max_duty: 16'hFFFF, motor_count: 4'd3, pulse_period: 16'd50,
					pulse_on_time: 16'd25, wave_step_time: 16'd7, beat_period: 16'd90,
					beat_on_time: 16'd20, beat_gap_time: 16'd15};
			end
			default: begin
				case ($urandom_range(0, 3))
					0: c.max_duty = 16'd255;
					1: c.max_duty = 16'hFFFF;
					default: c.max_duty = 16'($urandom);
				endcase
				c.motor_count    = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) :
					4'($urandom_range(1, 8));
				c.pulse_period   = 16'($urandom_range(1, 2000));
				c.pulse_on_time  = 16'($urandom_range(0, c.pulse_period + 100));
				c.wave_step_time = 16'($urandom_range(1, 500));
				c.beat_period    = 16'($urandom_range(1, 2000));
				c.beat_on_time   = 16'($urandom_range(0, c.beat_period / 3));
				c.beat_gap_time  = 16'($urandom_range(0, c.beat_period / 3));
			end
		endcase
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   sel;
		c.op = op_t'($urandom_range(0, 3));
		sel  = $urandom_range(0, 19);
		if (sel < 14) begin
			c.intensity = 16'($urandom_range(0, 100));
		end else if (sel < 17) begin
			c.intensity = 16'($urandom_range(101, 32767));
		end else begin
			c.intensity = 16'($urandom);
		end
		c.time_ms = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 8191);
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		cmd_t dir_q[$];
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_MAX_DUTY;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats on reset defaults: 8 motors, duty 255,
		// pulse 1000/500, wave step 200, heartbeat 1200 with 100/100
		dir_q = '{
			// intensity clamping at both ends and across 100
			mk_cmd(OP_CONST, 100, 0),          mk_cmd(OP_CONST, -32768, 0),
			mk_cmd(OP_CONST, 32767, 0),        mk_cmd(OP_CONST, 0, 0),
			mk_cmd(OP_CONST, 1, 0),            mk_cmd(OP_CONST, 99, 0),
			mk_cmd(OP_CONST, 101, 0),          mk_cmd(OP_CONST, -1, 32'hFFFF_FFFF),
			// pulse edges of the on window and the cycle wrap
			mk_cmd(OP_PULSE, 100, 499),        mk_cmd(OP_PULSE, 100, 500),
			mk_cmd(OP_PULSE, 77, 999),         mk_cmd(OP_PULSE, 77, 1000),
			mk_cmd(OP_PULSE, 50, 32'hFFFF_FFFF),
			// wave at motor 0, at the top motor wrapping to 0, and max time
			mk_cmd(OP_WAVE, 100, 0),           mk_cmd(OP_WAVE, 100, 1400),
			mk_cmd(OP_WAVE, 63, 32'hFFFF_FFFF),
			// heartbeat through first beat, gap, second beat, rest
			mk_cmd(OP_BEAT, 100, 0),           mk_cmd(OP_BEAT, 100, 99),
			mk_cmd(OP_BEAT, 100, 100),         mk_cmd(OP_BEAT, 100, 199),
			mk_cmd(OP_BEAT, 100, 200),         mk_cmd(OP_BEAT, 100, 299),
			mk_cmd(OP_BEAT, 100, 300),         mk_cmd(OP_BEAT, 90, 1199)
		};
		burst_left = $urandom_range(1, 16);
		foreach (dir_q[i]) begin
			send_cmd(dir_q[i]);
			after_beat(i == dir_q.size() - 1);
		end
		cmd_valid <= 1'b0;
		wait_idle();

		// random phases, each on its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			load_cfg(phase_cfg(ph));
			@(posedge clk);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long receiver hold-off while commands keep coming back to back
				if (ph == 5 && i == 2) begin
					hold_req   = 1'b1;
					burst_left = PHASE_ITEMS;
				end
				// sender waits mid-phase until every pending beat is out
				if (ph == 7 && i == PHASE_ITEMS / 2) begin
					cmd_valid <= 1'b0;
					@(posedge clk);
					while (sb.pending() != 0) @(posedge clk);
				end
				send_cmd(rand_cmd());
				after_beat(i == PHASE_ITEMS - 1);
			end
			cmd_valid <= 1'b0;
			wait_idle();
		end

		$display("checked %0d commands and %0d duty beats across %0d register settings",
			sb.cmds, sb.beats, settings);
		$display("patterns constant/pulse/wave/heartbeat, motor counts 0..15, zero periods");
		if (sb.errors == 0) begin
			$display("haptic_pattern_duty_generator_top_tb: PASS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("haptic_pattern_duty_generator_top_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: haptic_pattern_duty_generator_top.f
design/hpd_pkg.sv
design/hpd_front.sv
design/hpd_queue.sv
design/hpd_back.sv
design/haptic_pattern_duty_generator_top.sv
bench/haptic_pattern_duty_generator_top_tb.sv
